FILE: hw/rtl/sorted_rank_range_index_select_unit_macros.svh
// Assertion macros for the rank-window index selector.
// Used by the top level only; needs nothing else.
`ifndef SORTED_RANK_RANGE_INDEX_SELECT_UNIT_MACROS_SVH
`define SORTED_RANK_RANGE_INDEX_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRRIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SRRIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/srris_pkg.sv
// Shared types and constants for the rank-window index selector.
// No dependencies; used by every module of the block.
`default_nettype none

package srris_pkg;

  // Capacity of the sorting chain
  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 4;

  // Divide by ten as multiply by reciprocal and shift (exact below 1024+4)
  localparam int unsigned DEC_X_W   = CNT_W + 5;
  localparam int unsigned RECIP_W   = 8;
  localparam int unsigned RECIP_10  = 205;
  localparam int unsigned RECIP_SH  = 11;
  localparam int unsigned DEC_Q_W   = DEC_X_W + RECIP_W - RECIP_SH;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_QUARTILE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_QUARTILE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TENTH_CHUNK    = 2'd3;

  // Range modes
  localparam logic MODE_QUARTILE = 1'b0;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_EMIT
  } srris_state_e;

  typedef struct packed {
    logic               range_mode;
    logic [1:0]         lower_quartile;
    logic [2:0]         upper_quartile;
    logic [3:0]         tenth_chunk;
  } srris_cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } srris_entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } srris_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srris_cell.sv
// One cell of the insertion-sort chain: holds one value and its arrival index.
// Depends on srris_pkg.
`default_nettype none

module srris_cell (
  input  wire                        clk_i,
  input  srris_pkg::srris_cell_ctrl_t ctrl_i,
  input  wire                        occ_i,
  input  srris_pkg::srris_entry_t    new_i,
  input  srris_pkg::srris_entry_t    left_i,
  input  wire                        left_gt_i,
  input  srris_pkg::srris_entry_t    right_i,
  output srris_pkg::srris_entry_t    data_o,
  output logic                       gt_o
);

  srris_pkg::srris_entry_t data_q, data_d;

  // Flag this slot as lying after the new value: empty, or strictly greater
  always_comb begin
    gt_o = !occ_i || (data_q.value > new_i.value);
  end

  // Take the new value, take the left neighbour, or move towards the head
  always_comb begin
    data_d = data_q;
    if (ctrl_i.insert) begin
      if (gt_o) begin
        data_d = left_gt_i ? left_i : new_i;
      end
    end else if (ctrl_i.shift) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/srris_bounds.sv
// Rank window bounds from the set size and the configuration registers.
// Depends on srris_pkg.
`default_nettype none

module srris_bounds (
  input  srris_pkg::srris_cfg_t          cfg_i,
  input  wire [srris_pkg::CNT_W-1:0]     count_i,
  output logic [srris_pkg::CNT_W-1:0]    start_o,
  output logic [srris_pkg::CNT_W-1:0]    end_o,
  output logic                           empty_o
);

  localparam int unsigned QW = srris_pkg::CNT_W + 3;
  localparam int unsigned XW = srris_pkg::DEC_X_W;
  localparam int unsigned PW = srris_pkg::DEC_X_W + srris_pkg::RECIP_W;
  localparam int unsigned DW = srris_pkg::DEC_Q_W;

  logic [2:0]    ub_sat;
  logic [QW-1:0] q_lo_prod, q_hi_prod;
  logic [XW-1:0] x_lo, x_hi;
  logic [PW-1:0] p_lo, p_hi;
  logic [DW-1:0] lo_raw, hi_raw, n_ext;
  logic [DW-1:0] lo_sat, hi_sat;

  // Quartile bounds: product then divide by four
  always_comb begin
    ub_sat    = (cfg_i.upper_quartile > 3'd4) ? 3'd4 : cfg_i.upper_quartile;
    q_lo_prod = QW'(cfg_i.lower_quartile) * QW'(count_i);
    q_hi_prod = QW'(ub_sat) * QW'(count_i);
  end

  // Decile bounds: divide by ten through the reciprocal
  always_comb begin
    x_lo = XW'(count_i) * XW'(cfg_i.tenth_chunk);
    x_hi = XW'(count_i) * (XW'(cfg_i.tenth_chunk) + XW'(1));
    p_lo = PW'(x_lo) * PW'(srris_pkg::RECIP_10);
    p_hi = PW'(x_hi) * PW'(srris_pkg::RECIP_10);
  end

  // Select the mode, clamp at the set size, flag an empty window
  always_comb begin
    n_ext = DW'(count_i);
    if (cfg_i.range_mode == srris_pkg::MODE_QUARTILE) begin
      lo_raw = DW'(q_lo_prod >> 2);
      hi_raw = DW'(q_hi_prod >> 2);
    end else begin
      lo_raw = DW'(p_lo >> srris_pkg::RECIP_SH);
      hi_raw = DW'(p_hi >> srris_pkg::RECIP_SH);
    end
    lo_sat  = (lo_raw > n_ext) ? n_ext : lo_raw;
    hi_sat  = (hi_raw > n_ext) ? n_ext : hi_raw;
    start_o = srris_pkg::CNT_W'(lo_sat);
    end_o   = srris_pkg::CNT_W'(hi_sat);
    empty_o = (lo_sat >= hi_sat);
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_rank_range_index_select_unit.sv
// Loading: one value per cycle, each inserted into the sorting chain as it is taken.
// After the item marked last, the calc state forms the rank window, the chain shifts
// down per rank below the start, then one result per cycle while the output is free.
// No input is taken from the last item until the final result is registered.
// Reset clears the set size, overflow flag, state and output valid; configuration
// returns to quartile mode over the full range. Chain contents are not reset.
`default_nettype none

`include "sorted_rank_range_index_select_unit_macros.svh"

module sorted_rank_range_index_select_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [srris_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [srris_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire [srris_pkg::VAL_W-1:0]         sample_value_i,
  input  wire                                final_item_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [srris_pkg::IDX_W-1:0]        arrival_index_o,
  output logic                               run_end_o,
  output logic                               window_empty_o,
  output logic                               capacity_exceeded_o
);

  localparam int unsigned N  = srris_pkg::MAX_ITEMS;
  localparam int unsigned CW = srris_pkg::CNT_W;

  srris_pkg::srris_state_e     state_q, state_d;
  srris_pkg::srris_cfg_t       cfg_q;
  logic [CW-1:0]               count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic [CW-1:0]               start_q, end_q, rank_q, rank_d;
  logic                        empty_q;
  logic [CW-1:0]               bnd_start, bnd_end;
  logic                        bnd_empty;

  logic                        out_valid_q, out_valid_d;
  logic [srris_pkg::IDX_W-1:0] out_idx_q;
  logic                        out_end_q, out_empty_q, out_ovf_q;

  srris_pkg::srris_cell_ctrl_t cell_ctrl;
  srris_pkg::srris_entry_t     new_entry;
  srris_pkg::srris_entry_t     cell_data [N];
  logic [N-1:0]                cell_gt;

  logic in_xfer, has_room, out_free, skip, emit, done, calc;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_mode     <= 1'b0;
      cfg_q.lower_quartile <= 2'd0;
      cfg_q.upper_quartile <= 3'd4;
      cfg_q.tenth_chunk    <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srris_pkg::REG_RANGE_MODE:     cfg_q.range_mode     <= cfg_data_i[0];
        srris_pkg::REG_LOWER_QUARTILE: cfg_q.lower_quartile <= cfg_data_i[1:0];
        srris_pkg::REG_UPPER_QUARTILE: cfg_q.upper_quartile <= cfg_data_i[2:0];
        srris_pkg::REG_TENTH_CHUNK:    cfg_q.tenth_chunk    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Window bounds for the current set size
  srris_bounds u_bounds (
    .cfg_i   (cfg_q),
    .count_i (count_q),
    .start_o (bnd_start),
    .end_o   (bnd_end),
    .empty_o (bnd_empty)
  );

  // Sorting chain
  assign new_entry.value = sample_value_i;
  assign new_entry.index = srris_pkg::IDX_W'(count_q);

  for (genvar i = 0; i < N; i++) begin : g_cell
    srris_pkg::srris_entry_t left_d, right_d;
    logic                    left_gt;
    logic                    occ;

    if (i == 0) begin : g_head
      assign left_d  = new_entry;
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_d  = cell_data[i-1];
      assign left_gt = cell_gt[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_mid
      assign right_d = cell_data[i+1];
    end

    assign occ = (CW'(i) < count_q);

    srris_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .occ_i     (occ),
      .new_i     (new_entry),
      .left_i    (left_d),
      .left_gt_i (left_gt),
      .right_i   (right_d),
      .data_o    (cell_data[i]),
      .gt_o      (cell_gt[i])
    );
  end

  // Control outputs of the sequencer
  always_comb begin
    in_ready_o       = 1'b0;
    calc             = 1'b0;
    skip             = 1'b0;
    emit             = 1'b0;
    done             = 1'b0;
    out_free         = !out_valid_q || out_ready_i;
    has_room         = (count_q < CW'(N));
    cell_ctrl.insert = 1'b0;
    cell_ctrl.shift  = 1'b0;
    case (state_q)
      srris_pkg::ST_LOAD: begin
        in_ready_o       = 1'b1;
        cell_ctrl.insert = in_valid_i && has_room;
      end
      srris_pkg::ST_CALC: begin
        calc = 1'b1;
      end
      srris_pkg::ST_EMIT: begin
        skip            = !empty_q && (rank_q < start_q);
        emit            = !skip && out_free;
        done            = emit && (empty_q || ((rank_q + CW'(1)) == end_q));
        cell_ctrl.shift = !empty_q && (skip || emit);
      end
      default: ;
    endcase
  end

  assign in_xfer = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srris_pkg::ST_LOAD: if (in_xfer && final_item_i) state_d = srris_pkg::ST_CALC;
      srris_pkg::ST_CALC: state_d = srris_pkg::ST_EMIT;
      srris_pkg::ST_EMIT: if (done) state_d = srris_pkg::ST_LOAD;
      default:            state_d = srris_pkg::ST_LOAD;
    endcase
  end

  // Set size, overflow flag and rank counter
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    rank_d  = rank_q;
    if (in_xfer) begin
      if (has_room) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (calc) begin
      rank_d = '0;
    end else if (cell_ctrl.shift) begin
      rank_d = rank_q + CW'(1);
    end
    if (done) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  // Hold the result register until the transfer, reload on emit
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srris_pkg::ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      rank_q      <= rank_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Latch window bounds and result payload
  always_ff @(posedge clk_i) begin
    if (calc) begin
      start_q <= bnd_start;
      end_q   <= bnd_end;
      empty_q <= bnd_empty;
    end
    if (emit) begin
      out_idx_q   <= empty_q ? '0 : cell_data[0].index;
      out_end_q   <= done;
      out_empty_q <= empty_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign arrival_index_o     = out_idx_q;
  assign run_end_o           = out_end_q;
  assign window_empty_o      = out_empty_q;
  assign capacity_exceeded_o = out_ovf_q;

  // Checks
  `SRRIS_ASSERT_IMP(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= CW'(N),
    "set size above capacity")
  `SRRIS_ASSERT_IMP(a_empty_ends, clk_i, rst_ni, out_valid_o && window_empty_o, run_end_o,
    "empty result not marked as run end")
  `SRRIS_ASSERT_NXT(a_final_stalls, clk_i, rst_ni, in_xfer && final_item_i, !in_ready_o,
    "input taken right after the last item")
  `SRRIS_ASSERT_IMP(a_rank_bound, clk_i, rst_ni,
    state_q == srris_pkg::ST_EMIT && !empty_q, rank_q < end_q,
    "rank counter passed window end")

endmodule

`default_nettype wire

FILE: tb/sv/tb_sorted_rank_range_index_select_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the rank-window index selector: sets of Q16.16 samples are
// streamed in and every emitted arrival index is checked against a sorted-set predictor.
// Depends on srris_pkg and sorted_rank_range_index_select_unit.
module tb_sorted_rank_range_index_select_unit;

  localparam int unsigned VAL_W     = srris_pkg::VAL_W;
  localparam int unsigned IDX_W     = srris_pkg::IDX_W;
  localparam int unsigned CFG_IDX_W = srris_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DAT_W = srris_pkg::CFG_DAT_W;
  localparam int unsigned MAX_ITEMS = srris_pkg::MAX_ITEMS;

  // Value flavours for generated sets
  localparam int KIND_FULL    = 0;
  localparam int KIND_TIES    = 1;
  localparam int KIND_EXTREME = 2;
  localparam int KIND_Q16     = 3;

  localparam int RANDOM_SAMPLES = 140;
  localparam int SETTLE_CYCLES  = 100;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             last;
  } sample_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             run_end;
    logic             empty;
    logic             ovf;
  } window_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [VAL_W-1:0]     sample_value = '0;
  logic                 final_item = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [IDX_W-1:0]     arrival_index_o;
  logic                 run_end_o;
  logic                 window_empty_o;
  logic                 capacity_exceeded_o;

  sorted_rank_range_index_select_unit u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .sample_value_i      (sample_value),
    .final_item_i        (final_item),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .arrival_index_o     (arrival_index_o),
    .run_end_o           (run_end_o),
    .window_empty_o      (window_empty_o),
    .capacity_exceeded_o (capacity_exceeded_o)
  );

  // Predictor state: sorted chain, set size, drop flag and register copies
  logic [VAL_W-1:0] chain_val [MAX_ITEMS];
  logic [IDX_W-1:0] chain_idx [MAX_ITEMS];
  int               held_count = 0;
  bit               dropped_flag = 1'b0;
  logic             mode_r = srris_pkg::MODE_QUARTILE;
  logic [1:0]       lq_r = 2'd0;
  logic [2:0]       uq_r = 3'd4;
  logic [3:0]       tc_r = 4'd0;

  sample_t     sample_q[$];
  window_res_t window_q[$];

  bit in_taken = 1'b0;
  bit idle_on = 1'b1;
  int in_gap = 0;
  int out_gap = 0;
  int mismatch_cnt = 0;
  int samples_in = 0;
  int results_checked = 0;
  int sets_run = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Insert one sample into the sorted set; on the last one, queue the window
  function automatic void absorb_sample(logic [VAL_W-1:0] v, logic last);
    int pos;
    int n;
    int start_r;
    int end_r;
    int ub;
    window_res_t r;
    if (held_count < MAX_ITEMS) begin
      pos = held_count;
      // equal values stay behind earlier arrivals
      for (int i = 0; i < held_count; i++) begin
        if ($signed(chain_val[i]) > $signed(v)) begin
          pos = i;
          break;
        end
      end
      for (int i = held_count; i > pos; i--) begin
        chain_val[i] = chain_val[i-1];
        chain_idx[i] = chain_idx[i-1];
      end
      chain_val[pos] = v;
      chain_idx[pos] = IDX_W'(held_count);
      held_count++;
    end else begin
      dropped_flag = 1'b1;
    end
    if (!last) return;

    n = held_count;
    if (mode_r == srris_pkg::MODE_QUARTILE) begin
      ub = (uq_r > 3'd4) ? 4 : int'(uq_r);
      start_r = int'(lq_r) * n / 4;
      end_r = ub * n / 4;
    end else begin
      start_r = n * int'(tc_r) / 10;
      end_r = n * (int'(tc_r) + 1) / 10;
    end
    if (start_r > n) start_r = n;
    if (end_r > n) end_r = n;

    if (start_r >= end_r) begin
      r.idx = '0;
      r.run_end = 1'b1;
      r.empty = 1'b1;
      r.ovf = dropped_flag;
      window_q = {window_q, r};
    end else begin
      for (int k = start_r; k < end_r; k++) begin
        r.idx = chain_idx[k];
        r.run_end = (k + 1 == end_r);
        r.empty = 1'b0;
        r.ovf = dropped_flag;
        window_q = {window_q, r};
      end
    end
    held_count = 0;
    dropped_flag = 1'b0;
  endfunction

  // Mostly back-to-back, some short pauses, a few long ones
  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VAL_W-1:0] gen_value(int kind);
    logic [VAL_W-1:0] v;
    case (kind)
      KIND_TIES: v = VAL_W'($urandom_range(0, 4)) - VAL_W'(2);
      KIND_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      KIND_Q16: v = VAL_W'($urandom_range(0, 200 * 65536)) - VAL_W'(100 * 65536);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic void push_sample(logic [VAL_W-1:0] v, logic last);
    sample_t s;
    s.value = v;
    s.last = last;
    sample_q = {sample_q, s};
  endfunction

  // Queue one complete set, filled at a rising edge so the driver picks it up cleanly
  task automatic queue_set(int size, int kind);
    @(posedge clk_i);
    for (int i = 0; i < size; i++) push_sample(gen_value(kind), i == size - 1);
    sets_run++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      srris_pkg::REG_RANGE_MODE:     mode_r = data[0];
      srris_pkg::REG_LOWER_QUARTILE: lq_r = data[1:0];
      srris_pkg::REG_UPPER_QUARTILE: uq_r = data[2:0];
      srris_pkg::REG_TENTH_CHUNK:    tc_r = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued sample is in and every window result is out;
  // look at rising edges, where the driver's last update has settled
  task automatic wait_drained();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || in_valid || window_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Input driver: hold until transfer, then insert a gap or present the next sample
  always @(negedge clk_i) begin : sample_driver
    sample_t s;
    if (rst_ni && !(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        s = sample_q.pop_front();
        sample_value <= s.value;
        final_item <= s.last;
        in_valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure
  always @(negedge clk_i) begin : ready_driver
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // Monitor: predict on each input transfer, check each result transfer
  always @(posedge clk_i) begin : window_monitor
    window_res_t got;
    window_res_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        absorb_sample(sample_value, final_item);
        in_taken = 1'b1;
        samples_in++;
      end
      if (out_valid_o && out_ready) begin
        got.idx = arrival_index_o;
        got.run_end = run_end_o;
        got.empty = window_empty_o;
        got.ovf = capacity_exceeded_o;
        if (window_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result idx=%0d end=%0b empty=%0b ovf=%0b", $realtime,
                     got.idx, got.run_end, got.empty, got.ovf);
        end else begin
          want = window_q.pop_front();
          results_checked++;
          if (got.idx !== want.idx || got.run_end !== want.run_end ||
              got.empty !== want.empty || got.ovf !== want.ovf) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $write("%0t: mismatch exp idx=%0d end=%0b empty=%0b ovf=%0b, ",
                     $realtime, want.idx, want.run_end, want.empty, want.ovf);
              $display("got idx=%0d end=%0b empty=%0b ovf=%0b",
                       got.idx, got.run_end, got.empty, got.ovf);
            end
          end
        end
      end
    end
  end

  // Stimulus sequence and verdict
  initial begin : stimulus
    int rand_samples;
    int size;
    int roll;
    rand_samples = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // lone minimum under the reset window
    @(posedge clk_i);
    push_sample(32'h8000_0000, 1'b1);
    sets_run++;
    wait_drained();

    // extremes and ties over the full range
    @(posedge clk_i);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0001_0000, 1'b1);
    sets_run++;
    wait_drained();

    // upper bound zero: empty window
    write_reg(srris_pkg::REG_UPPER_QUARTILE, 4'd0);
    queue_set(3, KIND_TIES);
    wait_drained();

    // top quarter, upper bound saturating from seven
    write_reg(srris_pkg::REG_LOWER_QUARTILE, 4'd3);
    write_reg(srris_pkg::REG_UPPER_QUARTILE, 4'hF);
    queue_set(4, KIND_EXTREME);
    wait_drained();

    // lower above upper: empty window
    write_reg(srris_pkg::REG_LOWER_QUARTILE, 4'd2);
    write_reg(srris_pkg::REG_UPPER_QUARTILE, 4'd1);
    queue_set(2, KIND_FULL);
    wait_drained();

    // last tenth
    write_reg(srris_pkg::REG_RANGE_MODE, 4'd1);
    write_reg(srris_pkg::REG_TENTH_CHUNK, 4'd9);
    queue_set(5, KIND_FULL);
    wait_drained();

    // tenth beyond nine: empty window
    write_reg(srris_pkg::REG_TENTH_CHUNK, 4'hF);
    queue_set(2, KIND_Q16);
    wait_drained();

    // range mode with upper data bits set drops back to quartile
    write_reg(srris_pkg::REG_RANGE_MODE, 4'hE);
    write_reg(srris_pkg::REG_LOWER_QUARTILE, 4'd0);
    write_reg(srris_pkg::REG_UPPER_QUARTILE, 4'd4);

    // random sets, first one overfills the chain
    while (rand_samples < RANDOM_SAMPLES) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) begin
        write_reg(srris_pkg::REG_RANGE_MODE, CFG_DAT_W'($urandom_range(0, 15)));
        write_reg(srris_pkg::REG_LOWER_QUARTILE, CFG_DAT_W'($urandom_range(0, 15)));
        write_reg(srris_pkg::REG_UPPER_QUARTILE, CFG_DAT_W'($urandom_range(0, 15)));
        write_reg(srris_pkg::REG_TENTH_CHUNK, CFG_DAT_W'($urandom_range(0, 15)));
      end
      roll = $urandom_range(0, 99);
      if (rand_samples == 0) size = MAX_ITEMS + 2;
      else if (roll < 8) size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
      else if (roll < 20) size = $urandom_range(20, MAX_ITEMS);
      else size = $urandom_range(1, 10);
      queue_set(size, $urandom_range(KIND_FULL, KIND_Q16));
      rand_samples += size;
      wait_drained();
    end

    // let any stray result show up
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d sets, %0d samples transferred, %0d window results checked",
             sets_run, samples_in, results_checked);
    $display("Mismatches: %0d, results still awaited: %0d", mismatch_cnt, window_q.size());
    if (mismatch_cnt == 0 && window_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/srris_pkg.sv
hw/rtl/srris_cell.sv
hw/rtl/srris_bounds.sv
hw/rtl/sorted_rank_range_index_select_unit.sv
tb/sv/tb_sorted_rank_range_index_select_unit.sv
